// File: rtl/core/particulate_window_aqi_unit_defines.svh
// Shared assertion macros for the particulate window index block
`ifndef PARTICULATE_WINDOW_AQI_UNIT_DEFINES_SVH
`define PARTICULATE_WINDOW_AQI_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define PWAQI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pwaqi check failed");

// Next-cycle implication, disabled while reset is held
`define PWAQI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pwaqi check failed");

`endif

// File: rtl/core/pwaqi_pkg.sv
package pwaqi_pkg;

    // Field widths
    localparam int unsigned READ_W  = 10;
    localparam int unsigned SUM_W   = 18;
    localparam int unsigned CNT_W   = 8;
    localparam int unsigned AVG_W   = 14;
    localparam int unsigned IDX_W   = 10;
    localparam int unsigned CAT_W   = 3;

    // Window clamp and segment search depth
    localparam int unsigned MAX_WINDOW = 255;
    localparam int unsigned SEGMENTS   = 6;
    localparam int unsigned TABLE_ROWS = 6;
    localparam int unsigned ROWS = (SEGMENTS < TABLE_ROWS) ? SEGMENTS : TABLE_ROWS;

    // Serial arithmetic widths
    localparam int unsigned DIV_W   = 23;  // dividend and quotient
    localparam int unsigned DSR_W   = 14;  // divisor
    localparam int unsigned SPAN_W  = 13;  // concentration span of a segment
    localparam int unsigned ILO_W   = 9;   // lower index of a segment
    localparam int unsigned IRNG_W  = 8;   // index range of a segment
    localparam int unsigned NUM_W   = AVG_W + IRNG_W;
    localparam int unsigned IDX_MAX = 1023;

    // Index category codes
    localparam logic [CAT_W-1:0] CAT_GOOD      = 3'd0;
    localparam logic [CAT_W-1:0] CAT_MODERATE  = 3'd1;
    localparam logic [CAT_W-1:0] CAT_SENSITIVE = 3'd2;
    localparam logic [CAT_W-1:0] CAT_UNHEALTHY = 3'd3;
    localparam logic [CAT_W-1:0] CAT_VERY_BAD  = 3'd4;
    localparam logic [CAT_W-1:0] CAT_HAZARD    = 3'd5;

    // Breakpoints, concentrations in tenths: {conc_lo, conc_hi, index_lo, index_hi}
    localparam int unsigned BP [3][TABLE_ROWS][4] = '{
        '{ '{0, 80, 0, 50}, '{81, 254, 51, 100}, '{255, 354, 101, 150},
           '{355, 504, 151, 200}, '{505, 754, 201, 300}, '{755, 5004, 301, 500} },
        '{ '{0, 120, 0, 50}, '{121, 354, 51, 100}, '{355, 554, 101, 150},
           '{555, 1504, 151, 200}, '{1505, 2504, 201, 300}, '{2505, 5004, 301, 500} },
        '{ '{0, 540, 0, 50}, '{550, 1540, 51, 100}, '{1550, 2540, 101, 150},
           '{2550, 3540, 151, 200}, '{3550, 4240, 201, 300}, '{4250, 6040, 301, 500} }
    };

    typedef struct packed {
        logic [AVG_W-1:0]  clo;
        logic [SPAN_W-1:0] span;
        logic [ILO_W-1:0]  ilo;
        logic [IRNG_W-1:0] irng;
    } t_seg;

    // Pick the last segment whose lower bound the concentration reaches
    function automatic t_seg seg_lookup(input logic [1:0] tbl, input logic [AVG_W-1:0] conc);
        t_seg        seg;
        int unsigned sel;
        int unsigned t;
        t   = (tbl > 2'd2) ? 2 : int'(tbl);
        sel = 0;
        for (int unsigned i = 0; i < ROWS; i++) begin
            if (32'(conc) >= BP[t][i][0]) begin
                sel = i;
            end
        end
        seg.clo  = AVG_W'(BP[t][sel][0]);
        seg.span = SPAN_W'(BP[t][sel][1] - BP[t][sel][0]);
        seg.ilo  = ILO_W'(BP[t][sel][2]);
        seg.irng = IRNG_W'(BP[t][sel][3] - BP[t][sel][2]);
        return seg;
    endfunction

endpackage

// File: rtl/core/particulate_window_aqi_unit.sv
// Particulate window air-quality index. Each input transaction carries one
// PM1.0/PM2.5/PM10 reading in ug/m3 and is summed as it is taken, so readings
// are taken back to back until the count reaches the window length written on
// the configuration channel (zero acts as one). The reading that closes a window
// starts the index computation, during which the input is not ready: three
// window averages in tenths of ug/m3, then one interpolated sub-index per
// pollutant, all through one shared bit-serial divider (six divisions) and
// one shift-add multiplier. The result sits in an output register; new
// readings are accepted while it waits to be taken.
module particulate_window_aqi_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: window length in readings
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    // Readings
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // pm1_reading, pm25_reading, pm10_reading, pad
    // Results
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [87:0] o_m_axis_tdata   // avg_pm1_tenths, avg_pm25_tenths,
                                         // avg_pm10_tenths, pm1_subindex,
                                         // pm25_subindex, pm10_subindex,
                                         // overall_index, index_category, pad
);
    import pwaqi_pkg::*;

    localparam logic [3:0] S_ACC       = 4'd0;
    localparam logic [3:0] S_AVG_GO    = 4'd1;
    localparam logic [3:0] S_AVG_WAIT  = 4'd2;
    localparam logic [3:0] S_SEG       = 4'd3;
    localparam logic [3:0] S_MUL_GO    = 4'd4;
    localparam logic [3:0] S_MUL_WAIT  = 4'd5;
    localparam logic [3:0] S_RDIV_GO   = 4'd6;
    localparam logic [3:0] S_RDIV_WAIT = 4'd7;
    localparam logic [3:0] S_OUT       = 4'd8;

    localparam logic [1:0] CH_PM1  = 2'd0;
    localparam logic [1:0] CH_PM25 = 2'd1;
    localparam logic [1:0] CH_PM10 = 2'd2;

    logic [3:0]        r_state, n_state;
    logic [1:0]        r_ch;
    logic              w_in_acc;
    logic              w_out_load;
    logic              w_window_end;
    logic [SUM_W-1:0]  w_sum1, w_sum25, w_sum10, w_sum_sel;
    logic [CNT_W-1:0]  w_count;
    logic [NUM_W-1:0]  w_sum_x10;
    logic [AVG_W-1:0]  r_avg1, r_avg25, r_avg10, w_avg_sel;
    logic [IDX_W-1:0]  r_sub1, r_sub25, r_sub10;
    t_seg              r_seg;
    t_seg              w_seg;
    logic [AVG_W-1:0]  r_diff;
    logic [NUM_W-1:0]  r_num;
    logic              w_div_start, w_div_done;
    logic [DIV_W-1:0]  w_div_dividend, w_div_quot;
    logic [DSR_W-1:0]  w_div_divisor;
    logic              w_mul_done;
    logic [NUM_W-1:0]  w_mul_prod;
    logic [DIV_W:0]    w_sub_wide;
    logic [IDX_W-1:0]  w_sub;
    logic [IDX_W-1:0]  w_top;
    logic [CAT_W-1:0]  w_cat;
    logic              r_out_valid;
    logic [87:0]       r_out_data;

    assign o_cfg_ready     = 1'b1;
    assign w_in_acc        = (r_state == S_ACC);
    assign o_s_axis_tready = w_in_acc;

    pwaqi_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_add        (i_s_axis_tvalid && w_in_acc),
        .i_pm1        (i_s_axis_tdata[9:0]),
        .i_pm25       (i_s_axis_tdata[19:10]),
        .i_pm10       (i_s_axis_tdata[29:20]),
        .i_clear      (w_out_load),
        .o_sum1       (w_sum1),
        .o_sum25      (w_sum25),
        .o_sum10      (w_sum10),
        .o_count      (w_count),
        .o_window_end (w_window_end)
    );

    // Select the channel under work
    always_comb begin
        unique case (r_ch)
            CH_PM1: begin
                w_sum_sel = w_sum1;
                w_avg_sel = r_avg1;
            end
            CH_PM25: begin
                w_sum_sel = w_sum25;
                w_avg_sel = r_avg25;
            end
            default: begin
                w_sum_sel = w_sum10;
                w_avg_sel = r_avg10;
            end
        endcase
    end

    assign w_sum_x10 = NUM_W'({w_sum_sel, 3'b000}) + NUM_W'({w_sum_sel, 1'b0});

    // Segment of the selected average
    assign w_seg = seg_lookup(r_ch, w_avg_sel);

    // Divider operands: the average, or the rounded interpolation quotient
    assign w_div_start = (r_state == S_AVG_GO) || (r_state == S_RDIV_GO);
    always_comb begin
        if (r_state == S_AVG_GO) begin
            w_div_dividend = DIV_W'(w_sum_x10);
            w_div_divisor  = DSR_W'(w_count);
        end else begin
            w_div_dividend = DIV_W'({r_num, 1'b0}) + DIV_W'(r_seg.span);
            w_div_divisor  = {r_seg.span, 1'b0};
        end
    end

    pwaqi_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    pwaqi_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_MUL_GO),
        .i_mcand (r_diff),
        .i_mplr  (r_seg.irng),
        .o_done  (w_mul_done),
        .o_prod  (w_mul_prod)
    );

    // Lower index plus rounded quotient, saturated
    assign w_sub_wide = {1'b0, w_div_quot} + (DIV_W + 1)'(r_seg.ilo);
    assign w_sub      = (w_sub_wide > (DIV_W + 1)'(IDX_MAX)) ? IDX_W'(IDX_MAX)
                                                              : w_sub_wide[IDX_W-1:0];

    // Largest sub-index and its category
    always_comb begin
        w_top = r_sub1;
        if (r_sub25 > w_top) begin
            w_top = r_sub25;
        end
        if (r_sub10 > w_top) begin
            w_top = r_sub10;
        end
    end

    always_comb begin
        priority if (w_top <= IDX_W'(50)) begin
            w_cat = CAT_GOOD;
        end else if (w_top <= IDX_W'(100)) begin
            w_cat = CAT_MODERATE;
        end else if (w_top <= IDX_W'(150)) begin
            w_cat = CAT_SENSITIVE;
        end else if (w_top <= IDX_W'(200)) begin
            w_cat = CAT_UNHEALTHY;
        end else if (w_top <= IDX_W'(300)) begin
            w_cat = CAT_VERY_BAD;
        end else begin
            w_cat = CAT_HAZARD;
        end
    end

    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || i_m_axis_tready);

    // Sequence the window-end computation
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_ACC:       if (w_window_end) n_state = S_AVG_GO;
            S_AVG_GO:    n_state = S_AVG_WAIT;
            S_AVG_WAIT:  if (w_div_done) n_state = (r_ch == CH_PM10) ? S_SEG : S_AVG_GO;
            S_SEG:       n_state = S_MUL_GO;
            S_MUL_GO:    n_state = S_MUL_WAIT;
            S_MUL_WAIT:  if (w_mul_done) n_state = S_RDIV_GO;
            S_RDIV_GO:   n_state = S_RDIV_WAIT;
            S_RDIV_WAIT: if (w_div_done) n_state = (r_ch == CH_PM10) ? S_OUT : S_SEG;
            S_OUT:       if (w_out_load) n_state = S_ACC;
            default:     n_state = S_ACC;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
            r_ch    <= CH_PM1;
        end else begin
            r_state <= n_state;
            if ((r_state == S_AVG_WAIT || r_state == S_RDIV_WAIT) && w_div_done) begin
                r_ch <= (r_ch == CH_PM10) ? CH_PM1 : r_ch + 2'd1;
            end
        end
    end

    // Capture averages, segment, product and sub-indices
    always_ff @(posedge i_clk) begin
        if (r_state == S_AVG_WAIT && w_div_done) begin
            unique case (r_ch)
                CH_PM1:  r_avg1  <= w_div_quot[AVG_W-1:0];
                CH_PM25: r_avg25 <= w_div_quot[AVG_W-1:0];
                default: r_avg10 <= w_div_quot[AVG_W-1:0];
            endcase
        end
        if (r_state == S_SEG) begin
            r_seg  <= w_seg;
            r_diff <= w_avg_sel - w_seg.clo;
        end
        if (r_state == S_MUL_WAIT && w_mul_done) begin
            r_num <= w_mul_prod;
        end
        if (r_state == S_RDIV_WAIT && w_div_done) begin
            unique case (r_ch)
                CH_PM1:  r_sub1  <= w_sub;
                CH_PM25: r_sub25 <= w_sub;
                default: r_sub10 <= w_sub;
            endcase
        end
    end

    // Output register: hold until the transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= {3'b000, w_cat, w_top, r_sub10, r_sub25, r_sub1,
                           r_avg10, r_avg25, r_avg1};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// File: rtl/core/pwaqi_accum.sv
module pwaqi_accum (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pwaqi_pkg::CNT_W-1:0]   i_cfg_data,
    input  logic                          i_add,
    input  logic [pwaqi_pkg::READ_W-1:0]  i_pm1,
    input  logic [pwaqi_pkg::READ_W-1:0]  i_pm25,
    input  logic [pwaqi_pkg::READ_W-1:0]  i_pm10,
    input  logic                          i_clear,
    output logic [pwaqi_pkg::SUM_W-1:0]   o_sum1,
    output logic [pwaqi_pkg::SUM_W-1:0]   o_sum25,
    output logic [pwaqi_pkg::SUM_W-1:0]   o_sum10,
    output logic [pwaqi_pkg::CNT_W-1:0]   o_count,
    output logic                          o_window_end
);
    import pwaqi_pkg::*;

    logic [CNT_W-1:0] r_window;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [SUM_W-1:0] r_sum1, r_sum25, r_sum10;
    logic [CNT_W-1:0] w_win;

    // Treat a zero window as one, clamp to the largest window
    always_comb begin
        if (i_cfg_data == '0 && r_window == '0) begin
            w_win = CNT_W'(1);
        end else if (r_window == '0) begin
            w_win = CNT_W'(1);
        end else if (32'(r_window) > MAX_WINDOW) begin
            w_win = CNT_W'(MAX_WINDOW);
        end else begin
            w_win = r_window;
        end
    end

    assign n_count      = r_count + CNT_W'(1);
    assign o_window_end = i_add && (n_count != '0) && (n_count >= w_win);

    // Hold the window length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= CNT_W'(60);
        end else if (i_cfg_we) begin
            r_window <= i_cfg_data;
        end
    end

    // Accumulate readings, drop them on clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum1  <= '0;
            r_sum25 <= '0;
            r_sum10 <= '0;
        end else if (i_clear) begin
            r_count <= '0;
            r_sum1  <= '0;
            r_sum25 <= '0;
            r_sum10 <= '0;
        end else if (i_add) begin
            r_count <= n_count;
            r_sum1  <= r_sum1 + SUM_W'(i_pm1);
            r_sum25 <= r_sum25 + SUM_W'(i_pm25);
            r_sum10 <= r_sum10 + SUM_W'(i_pm10);
        end
    end

    assign o_sum1  = r_sum1;
    assign o_sum25 = r_sum25;
    assign o_sum10 = r_sum10;
    assign o_count = r_count;

endmodule

// File: rtl/core/pwaqi_div.sv
module pwaqi_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [pwaqi_pkg::DIV_W-1:0]  i_dividend,
    input  logic [pwaqi_pkg::DSR_W-1:0]  i_divisor,
    output logic                         o_done,
    output logic [pwaqi_pkg::DIV_W-1:0]  o_quot
);
    import pwaqi_pkg::*;

    localparam int unsigned CW = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] r_quo;
    logic [DSR_W-1:0] r_rem;
    logic [DSR_W-1:0] r_dsr;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DSR_W:0]   w_shift;
    logic [DSR_W:0]   w_diff;
    logic             w_bit;

    // One quotient bit per cycle: shift in the next dividend bit, try subtract
    assign w_shift = {r_rem, r_quo[DIV_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dsr};
    assign w_bit   = (w_shift >= {1'b0, r_dsr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_W-2:0], w_bit};
            r_rem <= w_bit ? w_diff[DSR_W-1:0] : w_shift[DSR_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// File: rtl/core/pwaqi_mul.sv
module pwaqi_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pwaqi_pkg::AVG_W-1:0]   i_mcand,
    input  logic [pwaqi_pkg::IRNG_W-1:0]  i_mplr,
    output logic                          o_done,
    output logic [pwaqi_pkg::NUM_W-1:0]   o_prod
);
    import pwaqi_pkg::*;

    localparam int unsigned CW = $clog2(IRNG_W + 1);

    logic [NUM_W-1:0]  r_acc;
    logic [NUM_W-1:0]  r_mcand;
    logic [IRNG_W-1:0] r_mplr;
    logic [CW-1:0]     r_cnt;
    logic              r_busy;
    logic              r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(IRNG_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift-add over the multiplier bits, lowest first
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc   <= '0;
            r_mcand <= NUM_W'(i_mcand);
            r_mplr  <= i_mplr;
        end else if (r_busy) begin
            if (r_mplr[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand <= {r_mcand[NUM_W-2:0], 1'b0};
            r_mplr  <= {1'b0, r_mplr[IRNG_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// File: rtl/core/pwaqi_checker.sv
`include "particulate_window_aqi_unit_defines.svh"

module pwaqi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [87:0] o_m_axis_tdata
);
    import pwaqi_pkg::*;

    logic [IDX_W-1:0] w_sub1, w_sub25, w_sub10, w_top;
    logic [CAT_W-1:0] w_cat;
    logic             w_top_ge, w_top_eq, w_cat_ok;

    // Split the result fields
    assign w_sub1  = o_m_axis_tdata[51:42];
    assign w_sub25 = o_m_axis_tdata[61:52];
    assign w_sub10 = o_m_axis_tdata[71:62];
    assign w_top   = o_m_axis_tdata[81:72];
    assign w_cat   = o_m_axis_tdata[84:82];

    assign w_top_ge = (w_top >= w_sub1) && (w_top >= w_sub25) && (w_top >= w_sub10);
    assign w_top_eq = (w_top == w_sub1) || (w_top == w_sub25) || (w_top == w_sub10);
    assign w_cat_ok = (w_cat <= CAT_HAZARD)
                   && ((w_cat == CAT_GOOD) == (w_top <= IDX_W'(50)))
                   && ((w_cat == CAT_HAZARD) == (w_top > IDX_W'(300)));

    // Hold a stalled result
    `PWAQI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata))

    // Overall index is the largest sub-index
    `PWAQI_ASSERT_NOW(a_top_is_max, i_clk, i_rst_n, o_m_axis_tvalid, w_top_ge && w_top_eq)

    // Category agrees with the overall index at its ends
    `PWAQI_ASSERT_NOW(a_cat_bounds, i_clk, i_rst_n, o_m_axis_tvalid, w_cat_ok)

endmodule

bind particulate_window_aqi_unit pwaqi_checker u_pwaqi_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
